[hdl/klv_metadata_deframer_assert.svh]
// ----------------------------------------------------------------------------
// KLV metadata deframer assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef KLV_METADATA_DEFRAMER_ASSERT_SVH
`define KLV_METADATA_DEFRAMER_ASSERT_SVH

// same-cycle implication, muted during reset
`define KMD_ASSERT_NOW(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("kmd check failed");

// next-cycle implication, muted during reset
`define KMD_ASSERT_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("kmd check failed");

// next-cycle implication, live during reset
`define KMD_ASSERT_ALWAYS_NEXT(lbl, clk, a, b) \
    lbl: assert property (@(posedge clk) (a) |=> (b)) \
        else $error("kmd check failed");

`endif

[hdl/kmd_pkg.sv]
// ----------------------------------------------------------------------------
// KLV metadata deframer package
// Shared widths, kind and phase codes, and the queue push record.
// ----------------------------------------------------------------------------
`default_nettype none

package kmd_pkg;

    localparam int MAX_DEPTH = 8;
    localparam int LVL_W     = 3;   // index of one stack level
    localparam int NEST_W    = 4;   // count of open levels, 0..MAX_DEPTH
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;

    typedef logic [2:0] kind_t;

    localparam kind_t K_HDR      = 3'd0;
    localparam kind_t K_HDR_DONE = 3'd1;
    localparam kind_t K_PAYLOAD  = 3'd2;
    localparam kind_t K_PAD      = 3'd3;
    localparam kind_t K_END      = 3'd4;
    localparam kind_t K_DISCARD  = 3'd5;
    localparam kind_t K_ERROR    = 3'd6;

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_PAYLOAD = 3'd1;
    localparam logic [2:0] PH_PAD     = 3'd2;
    localparam logic [2:0] PH_SKIP    = 3'd3;
    localparam logic [2:0] PH_DISCARD = 3'd4;

    localparam logic [7:0] T_CHAR  = 8'h63;  // 'c'
    localparam logic [7:0] T_UBYTE = 8'h42;  // 'B'
    localparam logic [7:0] T_ULONG = 8'h4C;  // 'L'
    localparam logic [7:0] T_SLONG = 8'h6C;  // 'l'
    localparam logic [7:0] T_FLOAT = 8'h46;  // 'F'

    typedef struct packed {
        logic  valid;
        kind_t kind;
    } kmd_push_t;

endpackage

`default_nettype wire

[hdl/kmd_front.sv]
// ----------------------------------------------------------------------------
// KLV metadata deframer front end
// One byte per cycle unless the queue is full; the header/level parser classifies it.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wen,
    input  wire logic [31:0]        cfg_wdata,
    input  wire logic               in_valid,
    input  wire logic [7:0]         in_byte,
    input  wire logic               q_full,
    output logic                    in_ready,
    output kmd_pkg::kmd_push_t      push
);
    import kmd_pkg::*;

    logic [31:0]       lvl_reg  [MAX_DEPTH];
    logic [31:0]       lvl_next [MAX_DEPTH];
    logic [MAX_DEPTH-1:0] zero_reg, zero_next;
    logic [NEST_W-1:0] nest_reg, nest_next;
    logic [31:0]       hdr_reg, hdr_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [24:0]       pay_reg, pay_next;
    logic [1:0]        pad_reg, pad_next;
    logic [2:0]        phase_reg, phase_next;

    logic              take;
    kind_t             kind;
    logic [LVL_W-1:0]  top;
    logic [NEST_W-1:0] top_wide;
    logic [31:0]       rem;
    logic [31:0]       shifted;
    logic [7:0]        h_type, h_size;
    logic [15:0]       h_rep;
    logic [23:0]       total;
    logic [31:0]       clip;
    logic              over;
    logic [31:0]       left;
    logic [1:0]        pad_calc;
    logic [1:0]        pad_fit;
    logic              pad_over;
    logic              leaf;
    logic [24:0]       dec_pay;
    logic [1:0]        dec_pad;
    logic [NEST_W-1:0] pop_nest;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    assign top_wide = nest_reg - NEST_W'(1);
    assign top      = top_wide[LVL_W-1:0];
    assign rem      = lvl_reg[top] - 32'd1;
    assign shifted  = {hdr_reg[23:0], in_byte};
    assign h_type   = shifted[31:24];
    assign h_size   = shifted[23:16];
    assign h_rep    = shifted[15:0];
    assign total    = h_size * h_rep;
    assign over     = {8'd0, total} > rem;
    assign clip     = over ? rem : {8'd0, total};
    assign left     = rem - clip;
    assign pad_calc = 2'd0 - total[1:0];
    assign pad_over = {30'd0, pad_calc} > left;
    assign pad_fit  = pad_over ? left[1:0] : pad_calc;
    assign leaf     = (h_type == T_CHAR) || (h_type == T_UBYTE) || (h_type == T_ULONG)
                   || (h_type == T_SLONG) || (h_type == T_FLOAT);
    assign dec_pay  = (pay_reg != 25'd0) ? pay_reg - 25'd1 : 25'd0;
    assign dec_pad  = (pad_reg != 2'd0) ? pad_reg - 2'd1 : 2'd0;

    // find the highest open parent that still holds bytes
    always_comb begin
        pop_nest = '0;
        for (int j = 0; j < MAX_DEPTH; j++) begin
            if ((LVL_W'(j) < top) && !zero_reg[j]) begin
                pop_nest = NEST_W'(j + 1);
            end
        end
    end

    // parse one byte
    always_comb begin
        for (int i = 0; i < MAX_DEPTH; i++) lvl_next[i] = lvl_reg[i];
        zero_next  = zero_reg;
        nest_next  = nest_reg;
        hdr_next   = hdr_reg;
        cnt_next   = cnt_reg;
        pay_next   = pay_reg;
        pad_next   = pad_reg;
        phase_next = phase_reg;
        kind       = K_DISCARD;

        if (take && nest_reg != '0) begin
            lvl_next[top]  = rem;
            zero_next[top] = (rem == 32'd0);
            unique case (phase_reg)
                PH_HEADER: begin
                    hdr_next = shifted;
                    if (cnt_reg == 3'd3 && shifted == 32'd0) begin
                        cnt_next   = '0;
                        hdr_next   = '0;
                        phase_next = PH_DISCARD;
                        kind       = K_END;
                    end else if (cnt_reg == 3'd7) begin
                        cnt_next = '0;
                        kind     = over ? K_ERROR : K_HDR_DONE;
                        if (h_type == 8'd0) begin
                            if (nest_reg >= NEST_W'(MAX_DEPTH)) begin
                                pay_next   = clip[24:0];
                                phase_next = (clip != 32'd0) ? PH_SKIP : PH_HEADER;
                                kind       = K_ERROR;
                            end else begin
                                if (clip != 32'd0) begin
                                    lvl_next[top]        = left;
                                    zero_next[top]       = (left == 32'd0);
                                    lvl_next[top + 1'b1]  = clip;
                                    zero_next[top + 1'b1] = 1'b0;
                                    nest_next            = nest_reg + NEST_W'(1);
                                end
                                phase_next = PH_HEADER;
                            end
                        end else begin
                            if (pad_over) kind = K_ERROR;
                            if (leaf) begin
                                pay_next   = clip[24:0];
                                pad_next   = pad_fit;
                                phase_next = (clip != 32'd0) ? PH_PAYLOAD
                                           : ((pad_fit != 2'd0) ? PH_PAD : PH_HEADER);
                            end else begin
                                pay_next   = clip[24:0] + {23'd0, pad_fit};
                                pad_next   = '0;
                                phase_next = (pay_next != 25'd0) ? PH_SKIP : PH_HEADER;
                            end
                        end
                    end else begin
                        cnt_next = cnt_reg + 3'd1;
                        kind     = K_HDR;
                    end
                end
                PH_PAYLOAD: begin
                    kind     = K_PAYLOAD;
                    pay_next = dec_pay;
                    if (dec_pay == 25'd0) begin
                        phase_next = (pad_reg != 2'd0) ? PH_PAD : PH_HEADER;
                    end
                end
                PH_PAD: begin
                    kind     = K_PAD;
                    pad_next = dec_pad;
                    if (dec_pad == 2'd0) phase_next = PH_HEADER;
                end
                PH_SKIP: begin
                    kind     = K_DISCARD;
                    pay_next = dec_pay;
                    if (dec_pay == 25'd0) phase_next = PH_HEADER;
                end
                default: begin
                    kind = K_DISCARD;
                end
            endcase

            // close the emptied level and any emptied parents
            if (rem == 32'd0) begin
                nest_next  = pop_nest;
                phase_next = PH_HEADER;
                cnt_next   = '0;
                hdr_next   = '0;
                pay_next   = '0;
                pad_next   = '0;
            end
        end
    end

    assign push.valid = take;
    assign push.kind  = kind;

    // update parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_DEPTH; i++) lvl_reg[i] <= '0;
            zero_reg  <= '1;
            nest_reg  <= '0;
            hdr_reg   <= '0;
            cnt_reg   <= '0;
            pay_reg   <= '0;
            pad_reg   <= '0;
            phase_reg <= PH_HEADER;
        end else if (cfg_wen) begin
            for (int i = 1; i < MAX_DEPTH; i++) lvl_reg[i] <= '0;
            lvl_reg[0] <= cfg_wdata;
            zero_reg   <= {{(MAX_DEPTH-1){1'b1}}, (cfg_wdata == 32'd0)};
            nest_reg   <= (cfg_wdata != 32'd0) ? NEST_W'(1) : '0;
            hdr_reg    <= '0;
            cnt_reg    <= '0;
            pay_reg    <= '0;
            pad_reg    <= '0;
            phase_reg  <= PH_HEADER;
        end else begin
            for (int i = 0; i < MAX_DEPTH; i++) lvl_reg[i] <= lvl_next[i];
            zero_reg  <= zero_next;
            nest_reg  <= nest_next;
            hdr_reg   <= hdr_next;
            cnt_reg   <= cnt_next;
            pay_reg   <= pay_next;
            pad_reg   <= pad_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

[hdl/kmd_queue.sv]
// ----------------------------------------------------------------------------
// KLV metadata deframer kind queue
// Small FIFO of classified kinds between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire kmd_pkg::kmd_push_t push,
    input  wire logic               pop,
    output logic                    full,
    output logic                    q_valid,
    output kmd_pkg::kind_t          q_kind
);
    import kmd_pkg::*;

    kind_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_pop;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_kind  = mem_reg[rd_reg];
    assign do_pop  = pop && q_valid;

    always_comb begin
        cnt_next = cnt_reg;
        if (push.valid && !do_pop) cnt_next = cnt_reg + QCNT_W'(1);
        if (!push.valid && do_pop) cnt_next = cnt_reg - QCNT_W'(1);
    end

    // write entries
    always_ff @(posedge aclk) begin
        if (push.valid) mem_reg[wr_reg] <= push.kind;
    end

    // advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push.valid) wr_reg <= wr_reg + QPTR_W'(1);
            if (do_pop)     rd_reg <= rd_reg + QPTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[hdl/kmd_back.sv]
// ----------------------------------------------------------------------------
// KLV metadata deframer output stage
// Registers one kind at a time onto the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    input  wire kmd_pkg::kind_t     q_kind,
    output logic                    pop,
    output logic                    out_valid,
    output kmd_pkg::kind_t          out_kind,
    input  wire logic               out_ready
);
    import kmd_pkg::*;

    logic  valid_reg;
    kind_t kind_reg;
    logic  load;

    assign load      = !valid_reg || out_ready;
    assign pop       = load && q_valid;
    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;

    // hold while stalled, refill when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) kind_reg <= q_kind;
    end

endmodule

`default_nettype wire

[hdl/klv_metadata_deframer.sv]
// ----------------------------------------------------------------------------
// KLV metadata deframer
// Tags each byte of a key-length-value metadata atom with its role.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_axis    in   s_tvalid/s_tready  s_tdata[7:0] in_byte
// m_axis    out  m_tvalid/m_tready  m_tdata[2:0] kind, [7:3] zero
// cfg       in   cfg_wen            cfg_wdata[31:0] atom_length
//
// One byte per cycle unless the queue is full; the parser updates the level
// stack top in the cycle the byte is taken, and its kind leaves via the queue
// and then the output register. A four-entry queue and an output register
// decouple the sides, so output stalls only back up into s_tready once the queue
// is full. aresetn clears all control state; writing cfg restarts parsing.
// ----------------------------------------------------------------------------
`default_nettype none

module klv_metadata_deframer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wen,
    input  wire logic [31:0] cfg_wdata,   // atom_length
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] in_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata      // [2:0] kind, [7:3] zero
);
    import kmd_pkg::*;

    kmd_push_t push;
    logic      q_full;
    logic      q_valid;
    kind_t     q_kind;
    logic      pop;
    kind_t     out_kind;

    kmd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_byte   (s_tdata),
        .q_full    (q_full),
        .in_ready  (s_tready),
        .push      (push)
    );

    kmd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .full    (q_full),
        .q_valid (q_valid),
        .q_kind  (q_kind)
    );

    kmd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_kind    (q_kind),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_kind  (out_kind),
        .out_ready (m_tready)
    );

    assign m_tdata = {5'd0, out_kind};

endmodule

`default_nettype wire

[hdl/kmd_checker.sv]
// ----------------------------------------------------------------------------
// KLV metadata deframer port checker
// Watches the top-level ports for output stream rules.
// ----------------------------------------------------------------------------
`default_nettype none

`include "klv_metadata_deframer_assert.svh"

module kmd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata
);
    // hold a stalled item
    `KMD_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `KMD_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    // only defined kinds, zero fill above
    `KMD_ASSERT_NOW(a_kind_code, aclk, aresetn, m_tvalid,
        (m_tdata[7:3] == 5'd0) && (m_tdata[2:0] != 3'd7))
    // nothing leaves right after reset
    `KMD_ASSERT_ALWAYS_NEXT(a_reset_idle, aclk, !aresetn, !m_tvalid)

endmodule

bind klv_metadata_deframer kmd_checker u_kmd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[test/klv_deframer_checker.sv]
// ----------------------------------------------------------------------------
// KLV deframer kind checker
// Watches the byte and kind channels, predicts each kind from its own copy of
// the parser state and compares every kind taken, in order.
// ----------------------------------------------------------------------------
module klv_deframer_checker
    import kmd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    output int          fail_count,
    output int          kinds_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // parser mirror
    logic [31:0] lvl_left [MAX_DEPTH];
    int          open_lvls;
    logic [63:0] hdr_bytes;
    int          hdr_cnt;
    logic [31:0] body_left;
    logic [1:0]  pad_cnt;
    logic [2:0]  ph;

    kind_t kind_q[$];

    assign kinds_pending = kind_q.size();

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic void drop_item();
        ph = PH_HEADER;
        hdr_cnt = 0;
        hdr_bytes = '0;
        body_left = '0;
        pad_cnt = '0;
    endfunction

    function automatic bit leaf_type(input logic [7:0] t);
        return t == T_CHAR || t == T_UBYTE || t == T_ULONG || t == T_SLONG
            || t == T_FLOAT;
    endfunction

    function automatic kind_t close_header(input logic [31:0] rem);
        logic [7:0]  typ;
        logic [31:0] total, child, body, pad;
        bit          err;
        typ = hdr_bytes[31:24];
        total = 32'(hdr_bytes[23:16]) * 32'(hdr_bytes[15:0]);
        err = 0;
        if (typ == 8'h00) begin
            child = total;
            if (child > rem) begin
                child = rem;
                err = 1;
            end
            if (open_lvls >= MAX_DEPTH) begin
                body_left = child;
                ph = (child != 0) ? PH_SKIP : PH_HEADER;
                return K_ERROR;
            end
            if (child != 0) begin
                lvl_left[open_lvls-1] = rem - child;
                lvl_left[open_lvls] = child;
                open_lvls++;
            end
            ph = PH_HEADER;
        end else begin
            pad = (4 - (total & 3)) & 3;
            body = total;
            if (body > rem) begin
                body = rem;
                err = 1;
            end
            if (pad > rem - body) begin
                pad = rem - body;
                err = 1;
            end
            if (leaf_type(typ)) begin
                body_left = body;
                pad_cnt = pad[1:0];
                ph = (body != 0) ? PH_PAYLOAD : ((pad != 0) ? PH_PAD : PH_HEADER);
            end else begin
                body_left = body + pad;
                pad_cnt = '0;
                ph = (body_left != 0) ? PH_SKIP : PH_HEADER;
            end
        end
        return err ? K_ERROR : K_HDR_DONE;
    endfunction

    function automatic kind_t tag_byte(input logic [7:0] b);
        kind_t k;
        int    top;
        k = K_DISCARD;
        if (open_lvls == 0) return K_DISCARD;
        top = open_lvls - 1;
        lvl_left[top]--;
        case (ph)
            PH_HEADER: begin
                hdr_bytes = {hdr_bytes[55:0], b};
                if (hdr_cnt == 3 && hdr_bytes[31:0] == 0) begin
                    hdr_cnt = 0;
                    hdr_bytes = '0;
                    ph = PH_DISCARD;
                    k = K_END;
                end else if (hdr_cnt == 7) begin
                    hdr_cnt = 0;
                    k = close_header(lvl_left[top]);
                end else begin
                    hdr_cnt++;
                    k = K_HDR;
                end
            end
            PH_PAYLOAD: begin
                k = K_PAYLOAD;
                if (body_left != 0) body_left--;
                if (body_left == 0) ph = (pad_cnt != 0) ? PH_PAD : PH_HEADER;
            end
            PH_PAD: begin
                k = K_PAD;
                if (pad_cnt != 0) pad_cnt--;
                if (pad_cnt == 0) ph = PH_HEADER;
            end
            PH_SKIP: begin
                if (body_left != 0) body_left--;
                if (body_left == 0) ph = PH_HEADER;
            end
            default: k = K_DISCARD;
        endcase
        if (lvl_left[open_lvls-1] == 0) begin
            while (open_lvls != 0 && lvl_left[open_lvls-1] == 0) open_lvls--;
            drop_item();
        end
        return k;
    endfunction

    initial fail_count = 0;

    // advance the mirror and compare on every edge
    always @(posedge aclk) begin
        kind_t want;
        if (!aresetn) begin
            foreach (lvl_left[i]) lvl_left[i] = '0;
            open_lvls = 0;
            drop_item();
            kind_q.delete();
        end else begin
            if (cfg_wen) begin
                foreach (lvl_left[i]) lvl_left[i] = '0;
                lvl_left[0] = cfg_wdata;
                open_lvls = (cfg_wdata != 0) ? 1 : 0;
                drop_item();
            end
            if (s_tvalid && s_tready) kind_q.push_back(tag_byte(s_tdata));
            if (m_tvalid && m_tready) begin
                if (kind_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected kind %0d", m_tdata[2:0]));
                end else begin
                    want = kind_q.pop_front();
                    if (m_tdata[2:0] !== want)
                        report_mismatch($sformatf("kind %0d, expected %0d",
                                                  m_tdata[2:0], want));
                    if (m_tdata[7:3] !== 5'd0)
                        report_mismatch($sformatf("upper bits %0h", m_tdata[7:3]));
                end
            end
        end
    end
endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// KLV deframer testbench
// Feeds atoms built from headers, payloads, nesting and end keys, plus random
// noise, under random idling on both sides; the checker grades each kind.
// ----------------------------------------------------------------------------
module tb_top;
    import kmd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 4000;

    logic        aclk, aresetn;
    logic        cfg_wen;
    logic [31:0] cfg_wdata;
    logic        s_tvalid, s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid, m_tready;
    logic [7:0]  m_tdata;
    int          fail_count, kinds_pending;
    bit          calm;
    int          idle_cycles;

    logic [7:0] atom_bytes[$];

    klv_metadata_deframer dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    klv_deframer_checker chk (
        .aclk(aclk), .aresetn(aresetn), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .kinds_pending(kinds_pending)
    );

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // receiver stalls in bursts
    initial begin
        int n;
        m_tready = 0;
        forever begin
            m_tready <= 1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            if (!calm && $urandom_range(0, 1)) begin
                n = $urandom_range(1, 18);
                m_tready <= 0;
                repeat (n) @(posedge aclk);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_kinds();
        s_tvalid <= 0;
        @(posedge aclk);
        while (kinds_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_atom_length(input logic [31:0] len);
        cfg_wen <= 1;
        cfg_wdata <= len;
        @(posedge aclk);
        cfg_wen <= 0;
    endtask

    task automatic push_header(input logic [31:0] key, input logic [7:0] typ,
                               input logic [7:0] sz, input logic [15:0] rep);
        atom_bytes.push_back(key[31:24]);
        atom_bytes.push_back(key[23:16]);
        atom_bytes.push_back(key[15:8]);
        atom_bytes.push_back(key[7:0]);
        atom_bytes.push_back(typ);
        atom_bytes.push_back(sz);
        atom_bytes.push_back(rep[15:8]);
        atom_bytes.push_back(rep[7:0]);
    endtask

    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 9))
            0: return T_CHAR;
            1: return T_UBYTE;
            2: return T_ULONG;
            3: return T_SLONG;
            4: return T_FLOAT;
            5, 6: return 8'h00;
            7: return 8'h53;
            default: return 8'($urandom);
        endcase
    endfunction

    // random, mostly well-formed atom; small sizes, occasional large claims
    task automatic build_atom(input int depth);
        int          items;
        logic [7:0]  typ, sz;
        logic [15:0] rep;
        int          total;
        items = $urandom_range(1, 4);
        for (int i = 0; i < items; i++) begin
            typ = pick_type();
            if (typ == 8'h00 && depth < 10) begin
                push_header($urandom | 32'h1, 8'h00, 8'd1, 16'($urandom_range(0, 40)));
                build_atom(depth + 1);
            end else begin
                sz  = 8'($urandom_range(0, 4));
                rep = 16'($urandom_range(0, 4));
                if ($urandom_range(0, 15) == 0) begin
                    sz = 8'hFF;
                    rep = 16'hFFFF;
                end
                push_header($urandom | 32'h100, typ, sz, rep);
                total = sz * rep;
                if (total > 20) total = 20;
                for (int j = 0; j < total + ($urandom_range(0, 3)); j++)
                    atom_bytes.push_back(8'($urandom));
            end
        end
        if ($urandom_range(0, 2) == 0) push_header(32'h0, 8'h00, 8'h00, 16'h0);
    endtask

    task automatic run_atom(input logic [31:0] len);
        drain_kinds();
        set_atom_length(len);
        while (atom_bytes.size() != 0) send_byte(atom_bytes.pop_front());
    endtask

    initial begin
        int sent;
        calm = 0;
        aresetn = 0;
        cfg_wen = 0;
        cfg_wdata = '0;
        s_tvalid = 0;
        s_tdata = '0;
        idle_cycles = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // no open level after reset
        send_byte(8'hFF);
        send_byte(8'h00);

        // leaf with pad and unknown type, atom length three bytes past the content
        push_header("DVNM", T_CHAR, 8'd1, 16'd3);
        atom_bytes.push_back("a"); atom_bytes.push_back("b"); atom_bytes.push_back("c");
        atom_bytes.push_back(8'h00);
        push_header("XTRA", 8'h7A, 8'd1, 16'd1);
        repeat (4) atom_bytes.push_back(8'h55);
        run_atom(32'd24 + 32'd3);

        // nested container, empty container, end key, then leftovers discarded
        push_header("DEVC", 8'h00, 8'd4, 16'd5);
        push_header("TSMP", T_ULONG, 8'd4, 16'd1);
        repeat (4) atom_bytes.push_back(8'hA5);
        push_header("EMPT", 8'h00, 8'd0, 16'd0);
        push_header(32'h0, 8'h00, 8'h00, 16'h0);
        repeat (4) atom_bytes.push_back(8'hFF);
        run_atom(32'd36);

        // overrun on a huge leaf within a short atom
        push_header("BIGF", T_FLOAT, 8'hFF, 16'hFFFF);
        repeat (6) atom_bytes.push_back(8'h81);
        run_atom(32'd14);

        // excess nesting past the stack limit
        for (int d = 0; d < MAX_DEPTH; d++)
            push_header("NEST", 8'h00, 8'd1, 16'(200 - 8 * d));
        repeat (4) atom_bytes.push_back(8'h3C);
        run_atom(32'd300);

        // zero length register, then maximum length
        atom_bytes.push_back(8'h12);
        run_atom(32'd0);
        push_header("SCAL", T_SLONG, 8'd4, 16'd1);
        repeat (4) atom_bytes.push_back(8'h7F);
        run_atom(32'hFFFF_FFFF);

        // random atoms, some lengths short or long against the content
        sent = 0;
        while (sent < 400) begin
            if (sent > 320) calm = 1;
            build_atom(0);
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 6)) atom_bytes.push_back(8'($urandom));
            sent += atom_bytes.size();
            case ($urandom_range(0, 5))
                0: run_atom(32'($urandom_range(1, atom_bytes.size())));
                1: run_atom(32'(atom_bytes.size() + $urandom_range(0, 16)));
                2: run_atom(32'hFFFF_FFFF);
                default: run_atom(32'(atom_bytes.size()));
            endcase
        end

        drain_kinds();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && kinds_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
